FILE: src/ufd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufd_pkg
// Shared constants and types of the binary frame deframer: sync codes,
// header layout, queue sizing and the operation record that goes from the
// front end to the back end.
// ----------------------------------------------------------------------------
package ufd_pkg;

   // Sync pair that opens every frame.
   localparam logic [7:0] SYNC_FIRST  = 8'hB5;
   localparam logic [7:0] SYNC_SECOND = 8'h62;

   // Reset value of the payload limit register.
   localparam logic [15:0] LIMIT_RESET = 16'd512;

   // Frame layout: six header bytes, the payload, two checksum bytes.
   localparam logic [8:0] HEADER_BYTES      = 9'd6;
   localparam logic [8:0] TRAILER_BYTES     = 9'd2;
   localparam logic [8:0] LENGTH_LOW_INDEX  = 9'd4;
   localparam logic [8:0] LENGTH_HIGH_INDEX = 9'd5;

   // Operation queue between front and back end.
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = 2;
   localparam int QUEUE_COUNT_BITS = 3;

   // One accepted byte turns into zero, one or two byte operations for the back end.
   typedef struct packed {
      logic       restart;      // a sync pair was seen, restart framing
      logic       two_ops;      // second_byte is an operation too
      logic [7:0] first_byte;
      logic [7:0] second_byte;
   } ufd_op_type;

endpackage

FILE: src/ufd_interfaces.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufd_interfaces
// Valid/ready channels of the deframer: received bytes, frame bytes out, and
// the payload limit write port.
// ----------------------------------------------------------------------------
interface ufd_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface ufd_frame_if;
   logic        valid;
   logic        ready;
   logic [7:0]  frame_byte;
   logic [7:0]  byte_index;
   logic        frame_start;
   logic        frame_done;
   logic        frame_abort;
   logic [15:0] payload_length;
   logic        run_last;

   modport source (output valid, output frame_byte, output byte_index,
                   output frame_start, output frame_done, output frame_abort,
                   output payload_length, output run_last, input ready);
   modport sink (input valid, input frame_byte, input byte_index,
                 input frame_start, input frame_done, input frame_abort,
                 input payload_length, input run_last, output ready);
endinterface

interface ufd_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] payload_limit;

   modport source (output valid, output payload_limit, input ready);
   modport sink (input valid, input payload_limit, output ready);
endinterface

FILE: src/ufd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufd_front
// Front end: accepts received bytes, holds back a 0xB5 until the next byte,
// and turns each byte into the byte operations the back end must run.
// ----------------------------------------------------------------------------
module ufd_front (
   input  logic                clock,
   input  logic                reset,
   ufd_byte_if.sink            req,
   output logic                push_valid,
   output ufd_pkg::ufd_op_type push_op,
   input  logic                push_ready
);
   import ufd_pkg::*;

   logic held_ff;
   logic held_in;
   logic accept;
   logic is_first;
   logic is_second;
   logic push_needed;

   // A transaction is taken whenever the queue has room.
   assign req.ready = push_ready;
   assign accept    = req.valid & push_ready;
   assign is_first  = (req.rx_byte == SYNC_FIRST);
   assign is_second = (req.rx_byte == SYNC_SECOND);

   // Classify the byte against the held sync byte.
   always_comb begin
      push_op.first_byte  = req.rx_byte;
      push_op.second_byte = req.rx_byte;
      push_op.restart     = 1'b0;
      push_op.two_ops     = 1'b0;
      push_needed         = !is_first;
      if (held_ff) begin
         // The held 0xB5 is released; the new byte follows unless it is
         // itself a 0xB5 that must now be held.
         push_needed         = 1'b1;
         push_op.first_byte  = SYNC_FIRST;
         push_op.restart     = is_second;
         push_op.two_ops     = is_second | !is_first;
      end
   end

   assign push_valid = accept & push_needed;

   // Every 0xB5 is held; any other byte clears the hold.
   assign held_in = accept ? is_first : held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
      end else begin
         held_ff <= held_in;
      end
   end

endmodule

FILE: src/ufd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufd_queue
// Short first-in first-out queue of byte operations that decouples the
// front end from the back end.
// ----------------------------------------------------------------------------
module ufd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  ufd_pkg::ufd_op_type push_op,
   output logic                push_ready,
   output logic                pop_valid,
   output ufd_pkg::ufd_op_type pop_op,
   input  logic                pop
);
   import ufd_pkg::*;

   ufd_op_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_in;
   logic [QUEUE_COUNT_BITS-1:0] count_ff;
   logic [QUEUE_COUNT_BITS-1:0] count_in;
   logic                        do_push;
   logic                        do_pop;

   assign push_ready = (count_ff != QUEUE_COUNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_op     = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop & pop_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

FILE: src/ufd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufd_back
// Back end: runs byte operations against the framing state, one per cycle
// while the output register has room, and loads the resulting bytes into it.
// ----------------------------------------------------------------------------
module ufd_back #(
   parameter int FRAME_BUFFER_BYTES = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                op_valid,
   input  ufd_pkg::ufd_op_type op,
   output logic                op_pop,
   input  logic [15:0]         payload_limit,
   ufd_frame_if.source         rsp
);
   import ufd_pkg::*;

   localparam logic [8:0] BUFFER_LIMIT = 9'(FRAME_BUFFER_BYTES);

   logic        in_frame_ff, in_frame_in;
   logic [8:0]  pos_ff, pos_in;
   logic [7:0]  low_ff, low_in;
   logic [15:0] length_ff, length_in;
   logic        phase_ff, phase_in;
   logic        valid_ff, valid_in;
   logic [7:0]  frame_byte_ff;
   logic [7:0]  byte_index_ff;
   logic        start_ff, done_ff, abort_ff, last_ff;
   logic [15:0] plen_ff;

   logic        restart_now;
   logic [7:0]  cur_byte;
   logic        eff_in_frame;
   logic [8:0]  eff_pos;
   logic        emits;
   logic        past_length;
   logic [15:0] eff_length;
   logic [16:0] end_count;
   logic [16:0] pos_count;
   logic        abort;
   logic        done;
   logic        post_in_frame;
   logic [8:0]  post_pos;
   logic        second_emits;
   logic        run_last;
   logic        out_free;
   logic        step;
   logic        load;

   // Operation decode: which byte runs now and the framing state it sees.
   assign restart_now  = op.restart & !phase_ff;
   assign cur_byte     = phase_ff ? op.second_byte : op.first_byte;
   assign eff_in_frame = restart_now | in_frame_ff;
   assign eff_pos      = restart_now ? '0 : pos_ff;
   assign emits        = eff_in_frame && (eff_pos < BUFFER_LIMIT);

   // Length capture, limit check and end-of-frame compare.
   assign past_length = (eff_pos >= LENGTH_HIGH_INDEX);
   assign eff_length  = (eff_pos == LENGTH_HIGH_INDEX) ? {cur_byte, low_ff} : length_ff;
   assign end_count   = 17'(eff_length) + 17'(HEADER_BYTES + TRAILER_BYTES);
   assign pos_count   = 17'(eff_pos) + 17'd1;
   assign abort       = past_length && (eff_length > payload_limit);
   assign done        = past_length && !abort && (pos_count >= end_count);

   // Framing state after this byte, and whether a second byte still lands.
   assign post_in_frame = !(abort | done);
   assign post_pos      = (abort | done) ? '0 : eff_pos + 9'd1;
   assign second_emits  = post_in_frame && (post_pos < BUFFER_LIMIT);
   assign run_last      = phase_ff | !op.two_ops | !second_emits;

   // A byte that gives a result waits for room in the output register.
   assign out_free = !valid_ff || rsp.ready;
   assign step     = op_valid && (!emits || out_free);
   assign load     = step && emits;
   assign op_pop   = step && (phase_ff || !op.two_ops);

   always_comb begin
      phase_in    = step ? (!phase_ff && op.two_ops) : phase_ff;
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      low_in      = low_ff;
      length_in   = length_ff;
      if (load) begin
         in_frame_in = post_in_frame;
         pos_in      = post_pos;
         length_in   = eff_length;
         if (eff_pos == LENGTH_LOW_INDEX) begin
            low_in = cur_byte;
         end
      end
   end

   assign valid_in = load | (valid_ff & !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         pos_ff      <= '0;
         low_ff      <= '0;
         length_ff   <= '0;
         phase_ff    <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
         pos_ff      <= pos_in;
         low_ff      <= low_in;
         length_ff   <= length_in;
         phase_ff    <= phase_in;
         valid_ff    <= valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (load) begin
         frame_byte_ff <= cur_byte;
         byte_index_ff <= eff_pos[7:0];
         start_ff      <= restart_now;
         done_ff       <= done;
         abort_ff      <= abort;
         plen_ff       <= past_length ? eff_length : '0;
         last_ff       <= run_last;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.frame_byte     = frame_byte_ff;
   assign rsp.byte_index     = byte_index_ff;
   assign rsp.frame_start    = start_ff;
   assign rsp.frame_done     = done_ff;
   assign rsp.frame_abort    = abort_ff;
   assign rsp.payload_length = plen_ff;
   assign rsp.run_last       = last_ff;

endmodule

FILE: src/ubx_frame_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_frame_deframer_core
// Finds binary frames that open with 0xB5 0x62 in a received byte stream and
// emits frame bytes within the buffer with index and start, done, abort flags.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one received byte per transaction. rsp_bus carries frame
//   bytes; a received byte gives zero, one or two of them, and run_last marks
//   the last one a byte caused. csr_bus writes the payload limit; it is always
//   ready and must be written only while the block is idle.
//   A received byte may be taken every cycle while the queue has room. A 0xB5
//   is held until the next byte arrives; its frame byte then goes out together
//   with that byte's. An accepted byte is registered in the queue, then in the
//   output register. The back end runs one byte operation per cycle while the
//   output register has room, so a byte that releases a held 0xB5 and is itself
//   kept gives two back-end operations. A four-entry queue absorbs these bursts.
//   Reset clears the framing state, the held sync byte, the queue and the
//   output register, and sets the payload limit to 512.
//   When the receiver stalls rsp_bus, the output holds its transaction, the
//   back end stops, and req_bus.ready drops once the queue is full.
// ----------------------------------------------------------------------------
module ubx_frame_deframer_core #(
   parameter int FRAME_BUFFER_BYTES = 256
) (
   input logic         clock,
   input logic         reset,
   ufd_byte_if.sink    req_bus,
   ufd_frame_if.source rsp_bus,
   ufd_csr_if.sink     csr_bus
);
   import ufd_pkg::*;

   logic [15:0] limit_ff;
   logic [15:0] limit_in;
   logic        push_valid;
   logic        push_ready;
   ufd_op_type  push_op;
   logic        pop_valid;
   ufd_op_type  pop_op;
   logic        pop;

   // Payload limit register.
   assign csr_bus.ready = 1'b1;
   assign limit_in      = csr_bus.valid ? csr_bus.payload_limit : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   ufd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .push_valid (push_valid),
      .push_op    (push_op),
      .push_ready (push_ready)
   );

   ufd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_op     (pop_op),
      .pop        (pop)
   );

   ufd_back #(
      .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .op_valid      (pop_valid),
      .op            (pop_op),
      .op_pop        (pop),
      .payload_limit (limit_ff),
      .rsp           (rsp_bus)
   );

endmodule

FILE: src/ufd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufd_checker
// Port-level checks of the deframer's result channel.
// ----------------------------------------------------------------------------
module ufd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  frame_byte,
   input logic [7:0]  byte_index,
   input logic        frame_start,
   input logic        frame_done,
   input logic        frame_abort,
   input logic [15:0] payload_length
);
   import ufd_pkg::*;

   // A stalled result transaction keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(frame_byte) && $stable(byte_index))
      else $error("result changed while stalled");

   // The output register is empty right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A frame start is the first sync byte at index zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_start |-> byte_index == 8'd0 && frame_byte == SYNC_FIRST)
      else $error("frame start on wrong byte");

   // Abort takes precedence over completion.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(frame_done && frame_abort))
      else $error("done and abort together");

   // Header bytes before the length is known carry no length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && byte_index < 8'd5 |-> payload_length == 16'd0 && !frame_done)
      else $error("length or done flag in header");

endmodule

bind ubx_frame_deframer_core ufd_checker u_ufd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .frame_byte     (rsp_bus.frame_byte),
   .byte_index     (rsp_bus.byte_index),
   .frame_start    (rsp_bus.frame_start),
   .frame_done     (rsp_bus.frame_done),
   .frame_abort    (rsp_bus.frame_abort),
   .payload_length (rsp_bus.payload_length)
);

FILE: tb/ubx_frame_deframer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_frame_deframer_core_tb
// Drives received byte streams into the frame deframer: a directed opening,
// then random frames, truncated frames, noise and held sync bytes under
// several payload limits. A scoreboard class predicts every frame byte with
// its flags and compares the results in order, while both channels stall at
// random and the receiver once holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module ubx_frame_deframer_core_tb;
   import ufd_pkg::*;

   localparam int CLOCK_HALF     = 4;
   localparam int RESET_CYCLES   = 9;
   localparam int BUFFER_BYTES   = 256;
   localparam int SETTLE_CYCLES  = 20;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;

   // One frame byte as it appears on the result channel.
   typedef struct packed {
      logic [7:0]  frame_byte;
      logic [7:0]  byte_index;
      logic        frame_start;
      logic        frame_done;
      logic        frame_abort;
      logic [15:0] payload_length;
      logic        run_last;
   } frame_rec_type;

   // Tracks the framing state of the block and holds the frame bytes that
   // are still due on the result channel.
   class deframe_scoreboard;
      frame_rec_type expected_frame_bytes[$];
      logic [15:0]   limit;
      logic          synced;
      logic [8:0]    position;
      logic [7:0]    length_lo;
      logic [15:0]   length_decl;
      logic          sync_held;
      int            errors;

      function new();
         limit       = LIMIT_RESET;
         synced      = 1'b0;
         position    = '0;
         length_lo   = '0;
         length_decl = '0;
         sync_held   = 1'b0;
         errors      = 0;
      endfunction

      function void set_limit(logic [15:0] value);
         limit = value;
      endfunction

      function int pending();
         return expected_frame_bytes.size();
      endfunction

      // Keeps one byte of the current frame; returns 1 when it gives a result.
      function int take_frame_byte(logic [7:0] value, logic start);
         frame_rec_type rec;
         int unsigned   idx;
         int unsigned   total;
         if (!synced || position >= BUFFER_BYTES) begin
            return 0;
         end
         idx = 32'(position);
         if (idx == LENGTH_LOW_INDEX) begin
            length_lo = value;
         end
         if (idx == LENGTH_HIGH_INDEX) begin
            length_decl = {value, length_lo};
         end
         rec = '0;
         rec.frame_byte  = value;
         rec.byte_index  = idx[7:0];
         rec.frame_start = start;
         if (idx >= LENGTH_HIGH_INDEX) begin
            rec.payload_length = length_decl;
            total = HEADER_BYTES + length_decl + TRAILER_BYTES;
            if (length_decl > limit) begin
               rec.frame_abort = 1'b1;
            end else if (idx + 1 >= total) begin
               rec.frame_done = 1'b1;
            end
         end
         expected_frame_bytes.push_back(rec);
         if (rec.frame_abort || rec.frame_done) begin
            synced   = 1'b0;
            position = '0;
         end else begin
            position = position + 9'd1;
         end
         return 1;
      endfunction

      // Works out the frame bytes that one accepted received byte releases.
      function void note_rx_byte(logic [7:0] value);
         frame_rec_type rec;
         int            count;
         count = 0;
         if (sync_held) begin
            sync_held = 1'b0;
            if (value == SYNC_SECOND) begin
               synced   = 1'b1;
               position = '0;
               count += take_frame_byte(SYNC_FIRST, 1'b1);
               count += take_frame_byte(value, 1'b0);
            end else begin
               count += take_frame_byte(SYNC_FIRST, 1'b0);
               if (value == SYNC_FIRST) begin
                  sync_held = 1'b1;
               end else begin
                  count += take_frame_byte(value, 1'b0);
               end
            end
         end else if (value == SYNC_FIRST) begin
            sync_held = 1'b1;
         end else begin
            count += take_frame_byte(value, 1'b0);
         end
         // The last frame byte of this transaction carries run_last.
         if (count > 0) begin
            rec = expected_frame_bytes.pop_back();
            rec.run_last = 1'b1;
            expected_frame_bytes.push_back(rec);
         end
      endfunction

      function void compare_field(string field, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_frame_byte(frame_rec_type got);
         frame_rec_type want;
         if (expected_frame_bytes.size() == 0) begin
            $error("unexpected frame byte %0h at index %0d", got.frame_byte, got.byte_index);
            errors++;
            return;
         end
         want = expected_frame_bytes.pop_front();
         compare_field("frame_byte", want.frame_byte, got.frame_byte);
         compare_field("byte_index", want.byte_index, got.byte_index);
         compare_field("frame_start", want.frame_start, got.frame_start);
         compare_field("frame_done", want.frame_done, got.frame_done);
         compare_field("frame_abort", want.frame_abort, got.frame_abort);
         compare_field("payload_length", want.payload_length, got.payload_length);
         compare_field("run_last", want.run_last, got.run_last);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   ufd_byte_if  req_chan();
   ufd_frame_if rsp_chan();
   ufd_csr_if   csr_chan();

   deframe_scoreboard sb;
   frame_rec_type     seen;
   int                sent_count    = 0;
   int                src_idle_pct  = 0;
   int                sink_idle_pct = 0;
   logic              quiet         = 1'b0;
   logic              hold_request  = 1'b0;
   logic [15:0]       limit_now     = LIMIT_RESET;

   ubx_frame_deframer_core #(
      .FRAME_BUFFER_BYTES(BUFFER_BYTES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_bus(req_chan),
      .rsp_bus(rsp_chan),
      .csr_bus(csr_chan)
   );

   always #CLOCK_HALF clock = ~clock;

   // Offers one received byte, after an optional idle burst, and waits for
   // its transaction.
   task automatic send_byte(input logic [7:0] value);
      if (!quiet && src_idle_pct > $urandom_range(0, 99)) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= value;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      sb.note_rx_byte(value);
      sent_count++;
   endtask

   // Writes the payload limit once the block has drained.
   task automatic write_limit(input logic [15:0] value);
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_chan.valid         <= 1'b1;
      csr_chan.payload_limit <= value;
      do @(posedge clock); while (!(csr_chan.valid && csr_chan.ready));
      csr_chan.valid <= 1'b0;
      sb.set_limit(value);
      limit_now = value;
   endtask

   // Payload bytes lean toward the first sync byte to exercise the held path.
   function automatic logic [7:0] payload_byte();
      if ($urandom_range(0, 15) == 0) begin
         return SYNC_FIRST;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // Sends a header declaring len payload bytes, then body further bytes.
   task automatic send_frame(input int len, input int body);
      logic [15:0] declared;
      declared = 16'(len);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'($urandom_range(0, 255)));
      send_byte(declared[7:0]);
      send_byte(declared[15:8]);
      for (int i = 0; i < body; i++) begin
         send_byte(payload_byte());
      end
   endtask

   // Picks a declared length: mostly short, some above the limit.
   function automatic int pick_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return $urandom_range(0, 12);
      end else if (roll < 75) begin
         return $urandom_range(13, 40);
      end else if (roll < 90 && limit_now < 16'hFFFF) begin
         if (roll < 82) begin
            return int'(limit_now) + 1;
         end
         return $urandom_range(int'(limit_now) + 1, 16'hFFFF);
      end else if (limit_now <= 60) begin
         return int'(limit_now);
      end
      return $urandom_range(41, 60);
   endfunction

   // Random traffic: mostly whole frames, the rest truncated frames, noise
   // and stray sync bytes.
   task automatic run_traffic(input int count);
      int target;
      int roll;
      int len;
      int noise;
      target = sent_count + count;
      while (sent_count < target) begin
         roll = $urandom_range(0, 99);
         if (roll < 65) begin
            len = pick_length();
            if (len > limit_now) begin
               send_frame(len, $urandom_range(0, 3));
            end else begin
               send_frame(len, len + 2);
            end
         end else if (roll < 75) begin
            len = $urandom_range(0, 30);
            send_frame(len, $urandom_range(0, len + 1));
         end else if (roll < 88) begin
            noise = $urandom_range(1, 6);
            for (int i = 0; i < noise; i++) begin
               case ($urandom_range(0, 3))
                  0: send_byte(SYNC_FIRST);
                  1: send_byte(SYNC_SECOND);
                  default: send_byte(8'($urandom_range(0, 255)));
               endcase
            end
         end else begin
            send_byte(SYNC_FIRST);
            if ($urandom_range(0, 1) == 0) begin
               send_byte(SYNC_FIRST);
            end else begin
               send_byte(8'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   // Result side: random stall bursts, plus one long hold-off on request.
   initial begin : sink_side
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (!quiet && sink_idle_pct > $urandom_range(0, 99)) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Every accepted result transaction goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready) begin
         seen.frame_byte     = rsp_chan.frame_byte;
         seen.byte_index     = rsp_chan.byte_index;
         seen.frame_start    = rsp_chan.frame_start;
         seen.frame_done     = rsp_chan.frame_done;
         seen.frame_abort    = rsp_chan.frame_abort;
         seen.payload_length = rsp_chan.payload_length;
         seen.run_last       = rsp_chan.run_last;
         sb.check_frame_byte(seen);
      end
   end

   // Ends the run when no channel has moved a transaction for too long.
   initial begin : watchdog
      int still_cycles;
      still_cycles = 0;
      while (still_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
             || (csr_chan.valid && csr_chan.ready)) begin
            still_cycles = 0;
         end else begin
            still_cycles++;
         end
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      sb = new();
      req_chan.valid         = 1'b0;
      req_chan.rx_byte       = '0;
      rsp_chan.ready         = 1'b0;
      csr_chan.valid         = 1'b0;
      csr_chan.payload_limit = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed opening under the reset limit.
      src_idle_pct  = 20;
      sink_idle_pct = 20;
      // Bytes while hunting are dropped.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(SYNC_SECOND);
      // A held sync byte that opens nothing.
      send_byte(SYNC_FIRST);
      send_byte(8'h00);
      // Two sync bytes in a row, the second one opens the frame.
      send_byte(SYNC_FIRST);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      // Empty payload: the frame completes on its last checksum byte.
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h00);
      // A sync byte as class, then the largest length, which aborts.
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_byte(SYNC_FIRST);
      send_byte(8'h02);
      send_byte(8'hFF);
      send_byte(8'hFF);
      // A new sync pair in the middle of a frame restarts it.
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_byte(8'h01);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);

      run_traffic(120);

      // Zero limit: only empty frames complete.
      src_idle_pct  = 0;
      sink_idle_pct = 30;
      write_limit(16'h0000);
      run_traffic(80);

      // Largest limit: a frame that just fills the buffer, then one that
      // overflows it and never completes.
      src_idle_pct  = 10;
      sink_idle_pct = 0;
      write_limit(16'hFFFF);
      send_frame(BUFFER_BYTES - HEADER_BYTES - TRAILER_BYTES,
                 BUFFER_BYTES - HEADER_BYTES);
      send_frame(16'hFFFF, BUFFER_BYTES - 2);
      run_traffic(40);

      // Small limit with a long hold-off on the result side.
      src_idle_pct  = 0;
      sink_idle_pct = 30;
      write_limit(16'($urandom_range(8, 40)));
      hold_request = 1'b1;
      run_traffic(120);

      // Last stretch without any idling.
      write_limit(16'($urandom_range(0, 16'hFFFF)));
      quiet = 1'b1;
      run_traffic(80);

      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
